>>> src/bcs_pkg.sv
`timescale 1ns / 1ps
package bcs_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int BUS_W  = 15;
  localparam int CUR_W  = 13;
  localparam int ADC_W  = 10;
  localparam int BAT_W  = 13;
  localparam int PCT_W  = 7;
  localparam int CNT_W  = 16;
  localparam int LOW_W  = 4;
  localparam int MA_W   = 12;
  localparam int PROD_W = ADC_W + 13;

  localparam logic [12:0] ADC_FULL_MV = 13'd5000;

  typedef enum logic [3:0] {
    ST_STAB    = 4'd0,
    ST_IDLE    = 4'd1,
    ST_WAIT    = 4'd2,
    ST_START   = 4'd3,
    ST_CHARGE  = 4'd4,
    ST_MEASURE = 4'd5,
    ST_ENDCHK  = 4'd6,
    ST_PULSE   = 4'd7,
    ST_DONE    = 4'd8
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_CURRENT  = 3'd0,
    REG_LOW_LIMIT    = 3'd1,
    REG_CHARGED_MV   = 3'd2,
    REG_PRESENT_MV   = 3'd3,
    REG_WAITING_MV   = 3'd4,
    REG_REQUEST_MA   = 3'd5,
    REG_MEASURE_EVERY = 3'd6,
    REG_STAB_POLLS   = 3'd7
  } cfg_reg_t;

  localparam int PCT_LEN = 13;
  localparam logic [BUS_W-1:0] PCT_MV [PCT_LEN] = '{
    15'd4200, 15'd4150, 15'd4100, 15'd4050, 15'd4000, 15'd3950, 15'd3900,
    15'd3800, 15'd3700, 15'd3450, 15'd3400, 15'd3350, 15'd3300
  };
  localparam logic [PCT_W-1:0] PCT_VAL [PCT_LEN] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10
  };

  // lowest table voltage above mv wins; full at or above the top entry
  function automatic logic [PCT_W-1:0] pct_of(input logic [BUS_W-1:0] mv);
    logic [PCT_W-1:0] pct;
    pct = '0;
    if (mv >= PCT_MV[0]) begin
      pct = PCT_VAL[0];
    end else if (mv >= PCT_MV[PCT_LEN-1]) begin
      for (int i = 0; i < PCT_LEN; i++) begin
        if (mv < PCT_MV[i]) begin
          pct = PCT_VAL[i];
        end
      end
    end
    return pct;
  endfunction

endpackage

>>> src/battery_charge_sequencer.sv
`timescale 1ns / 1ps
// Single-cell charger sequencer. Every input word is one sensor poll and
// yields exactly one result word, registered, in the cycle after acceptance.
// A poll is taken in every clock while the result register is empty or
// being drained, so the block sustains one word per cycle. Threshold
// registers are written through the cfg port while no poll is in flight;
// the user must keep to this, as the block itself does not enforce it.
module battery_charge_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // bus_mv[14:0], current_ma[27:15], bat_adc[37:28], budget_grant[38]
  input  logic [bcs_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // charge_enable[0], state_code[4:1], percent[11:5], battery_mv[26:12],
  // request_current[27], consumption_ma[40:28]
  output logic [bcs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bcs_pkg::*;

  logic [MA_W-1:0]  low_current_ma_r;
  logic [LOW_W-1:0] low_count_limit_r;
  logic [BAT_W-1:0] charged_mv_r, present_mv_r, waiting_mv_r;
  logic [MA_W-1:0]  request_ma_r;
  logic [CNT_W-1:0] measure_every_r, stabilize_polls_r;

  state_t           state_r, state_nxt;
  logic [LOW_W-1:0] low_cnt_r, low_cnt_nxt;
  logic [BUS_W-1:0] last_mv_r, last_mv_nxt;
  logic [CNT_W-1:0] poll_r, poll_nxt;
  logic [CNT_W-1:0] stab_r, stab_nxt;
  logic [CUR_W-1:0] reported_r, reported_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [BUS_W-1:0]  bus_mv;
  logic [CUR_W-1:0]  current_ma;
  logic [ADC_W-1:0]  bat_adc;
  logic              budget_grant;
  logic [PROD_W-1:0] prod;
  logic [BAT_W-1:0]  bat_mv;
  logic              ask;
  logic              cur_low;
  logic [LOW_W:0]    low_inc;
  logic [CNT_W:0]    poll_inc, stab_inc;
  logic              charge_en;
  logic              accept;

  assign bus_mv       = in_tdata[14:0];
  assign current_ma   = in_tdata[27:15];
  assign bat_adc      = in_tdata[37:28];
  assign budget_grant = in_tdata[38];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign prod    = PROD_W'(bat_adc) * PROD_W'(ADC_FULL_MV);
  assign bat_mv  = prod[PROD_W-1:ADC_W];
  assign cur_low = $signed({current_ma[CUR_W-1], current_ma})
                   < $signed({2'b00, low_current_ma_r});
  assign low_inc  = {1'b0, low_cnt_r} + 1'b1;
  assign poll_inc = {1'b0, poll_r} + 1'b1;
  assign stab_inc = {1'b0, stab_r} + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    low_cnt_nxt  = low_cnt_r;
    last_mv_nxt  = last_mv_r;
    poll_nxt     = poll_r;
    stab_nxt     = stab_r;
    reported_nxt = reported_r;
    ask          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (bat_mv > present_mv_r) begin
          ask = 1'b1;
          if (budget_grant) begin
            reported_nxt = {1'b0, request_ma_r};
            state_nxt    = ST_START;
          end else begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (bat_mv > waiting_mv_r) begin
          ask = 1'b1;
          if (budget_grant) begin
            reported_nxt = {1'b0, request_ma_r};
            state_nxt    = ST_START;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_START: begin
        low_cnt_nxt  = '0;
        poll_nxt     = '0;
        reported_nxt = {1'b0, request_ma_r};
        last_mv_nxt  = bus_mv;
        state_nxt    = ST_CHARGE;
      end
      ST_CHARGE: begin
        if (cur_low) begin
          low_cnt_nxt = low_inc[LOW_W] ? '1 : low_inc[LOW_W-1:0];
        end else begin
          low_cnt_nxt = '0;
        end
        if (cur_low && (low_inc > {1'b0, low_count_limit_r})) begin
          state_nxt = ST_ENDCHK;
        end else begin
          reported_nxt = current_ma;
          poll_nxt     = poll_inc[CNT_W] ? '1 : poll_inc[CNT_W-1:0];
          if (poll_inc >= {1'b0, measure_every_r}) begin
            state_nxt = ST_MEASURE;
          end
        end
      end
      ST_MEASURE: begin
        last_mv_nxt = bus_mv;
        poll_nxt    = '0;
        state_nxt   = ST_CHARGE;
      end
      ST_ENDCHK: begin
        last_mv_nxt = bus_mv;
        state_nxt   = (bus_mv > {2'b00, charged_mv_r}) ? ST_DONE : ST_PULSE;
      end
      ST_DONE: begin
        state_nxt = ST_DONE;
      end
      ST_STAB: begin
        stab_nxt = stab_inc[CNT_W] ? '1 : stab_inc[CNT_W-1:0];
        if (stab_inc >= {1'b0, stabilize_polls_r}) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        stab_nxt  = '0;
        state_nxt = ST_STAB;
      end
    endcase

    charge_en    = (state_nxt == ST_CHARGE) || (state_nxt == ST_PULSE);
    out_data_nxt = {7'b0, reported_nxt, ask, last_mv_nxt, pct_of(last_mv_nxt),
                    state_nxt, charge_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_STAB;
      low_cnt_r   <= '0;
      last_mv_r   <= '0;
      poll_r      <= '0;
      stab_r      <= '0;
      reported_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        low_cnt_r   <= low_cnt_nxt;
        last_mv_r   <= last_mv_nxt;
        poll_r      <= poll_nxt;
        stab_r      <= stab_nxt;
        reported_r  <= reported_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_current_ma_r  <= 12'd12;
      low_count_limit_r <= 4'd3;
      charged_mv_r      <= 13'd4100;
      present_mv_r      <= 13'd2500;
      waiting_mv_r      <= 13'd2000;
      request_ma_r      <= 12'd1000;
      measure_every_r   <= 16'd100;
      stabilize_polls_r <= 16'd100;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOW_CURRENT:   low_current_ma_r  <= cfg_wdata[MA_W-1:0];
        REG_LOW_LIMIT:     low_count_limit_r <= cfg_wdata[LOW_W-1:0];
        REG_CHARGED_MV:    charged_mv_r      <= cfg_wdata[BAT_W-1:0];
        REG_PRESENT_MV:    present_mv_r      <= cfg_wdata[BAT_W-1:0];
        REG_WAITING_MV:    waiting_mv_r      <= cfg_wdata[BAT_W-1:0];
        REG_REQUEST_MA:    request_ma_r      <= cfg_wdata[MA_W-1:0];
        REG_MEASURE_EVERY: measure_every_r   <= cfg_wdata[CNT_W-1:0];
        REG_STAB_POLLS:    stabilize_polls_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> tb/battery_charge_sequencer_test.sv
`timescale 1ns / 1ps
module battery_charge_sequencer_test;
  import bcs_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int MV_MARKS [13] = '{
    4200, 4150, 4100, 4050, 4000, 3950, 3900, 3800, 3700, 3450, 3400, 3350, 3300
  };

  typedef struct packed {
    logic              charge_enable;
    state_t            state_code;
    logic [PCT_W-1:0]  percent;
    logic [BUS_W-1:0]  battery_mv;
    logic              request_current;
    logic [CUR_W-1:0]  consumption_ma;
  } poll_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  battery_charge_sequencer dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  always #4 clk = ~clk;

  // sequencer image: thresholds
  logic [MA_W-1:0]  thr_low_ma;
  logic [LOW_W-1:0] low_limit;
  logic [BAT_W-1:0] full_mv;
  logic [BAT_W-1:0] present_thr;
  logic [BAT_W-1:0] wait_thr;
  logic [MA_W-1:0]  ask_ma;
  logic [CNT_W-1:0] measure_period;
  logic [CNT_W-1:0] settle_target;
  // sequencer image: state
  state_t           seq_state;
  logic [LOW_W-1:0] low_polls;
  logic [BUS_W-1:0] held_mv;
  logic [CNT_W-1:0] charge_polls;
  logic [CNT_W-1:0] settle_polls;
  logic [CUR_W-1:0] budget_ma;

  poll_result_t result_q[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int low_pct = 30;
  int ready_mode = 0;
  int ready_left = 0;
  logic [31:0] ready_bits = '0;

  task automatic reset_image();
    thr_low_ma = 12;
    low_limit = 3;
    full_mv = 4100;
    present_thr = 2500;
    wait_thr = 2000;
    ask_ma = 1000;
    measure_period = 100;
    settle_target = 100;
    seq_state = ST_STAB;
    low_polls = '0;
    held_mv = '0;
    charge_polls = '0;
    settle_polls = '0;
    budget_ma = '0;
  endtask

  function automatic logic [PCT_W-1:0] charge_percent(input logic [BUS_W-1:0] mv);
    if (mv >= 4150) return 100;
    if (mv >= 4100) return 95;
    if (mv >= 4050) return 90;
    if (mv >= 4000) return 85;
    if (mv >= 3950) return 80;
    if (mv >= 3900) return 75;
    if (mv >= 3800) return 70;
    if (mv >= 3700) return 60;
    if (mv >= 3450) return 50;
    if (mv >= 3400) return 40;
    if (mv >= 3350) return 30;
    if (mv >= 3300) return 20;
    return 0;
  endfunction

  task automatic advance_sequencer(input logic [BUS_W-1:0] bus, input logic [CUR_W-1:0] cur,
                                   input logic [ADC_W-1:0] adc, input logic grant,
                                   output poll_result_t r);
    logic [22:0] prod;
    logic [BAT_W-1:0] bat_mv;
    int cur_i;
    int nxt;
    logic ask;
    bit ended;
    prod = adc * 13'd5000;
    bat_mv = prod[22:10];
    cur_i = $signed(cur);
    ask = 1'b0;
    ended = 1'b0;
    case (seq_state)
      ST_STAB: begin
        nxt = settle_polls + 1;
        settle_polls = (nxt > 65535) ? 16'hFFFF : 16'(nxt);
        if (nxt >= int'(settle_target)) seq_state = ST_IDLE;
      end
      ST_IDLE: begin
        if (bat_mv > present_thr) begin
          ask = 1'b1;
          if (grant) begin
            budget_ma = {1'b0, ask_ma};
            seq_state = ST_START;
          end else begin
            seq_state = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (bat_mv > wait_thr) begin
          ask = 1'b1;
          if (grant) begin
            budget_ma = {1'b0, ask_ma};
            seq_state = ST_START;
          end
        end else begin
          seq_state = ST_IDLE;
        end
      end
      ST_START: begin
        low_polls = '0;
        charge_polls = '0;
        budget_ma = {1'b0, ask_ma};
        held_mv = bus;
        seq_state = ST_CHARGE;
      end
      ST_CHARGE: begin
        if (cur_i < int'(thr_low_ma)) begin
          nxt = low_polls + 1;
          low_polls = (nxt > 15) ? 4'd15 : 4'(nxt);
          if (nxt > int'(low_limit)) begin
            seq_state = ST_ENDCHK;
            ended = 1'b1;
          end
        end else begin
          low_polls = '0;
        end
        if (!ended) begin
          budget_ma = cur;
          nxt = charge_polls + 1;
          charge_polls = (nxt > 65535) ? 16'hFFFF : 16'(nxt);
          if (nxt >= int'(measure_period)) seq_state = ST_MEASURE;
        end
      end
      ST_MEASURE: begin
        held_mv = bus;
        charge_polls = '0;
        seq_state = ST_CHARGE;
      end
      ST_ENDCHK: begin
        held_mv = bus;
        seq_state = (bus > full_mv) ? ST_DONE : ST_PULSE;
      end
      ST_DONE: begin
      end
      default: begin
        settle_polls = '0;
        seq_state = ST_STAB;
      end
    endcase
    r.charge_enable = (seq_state == ST_CHARGE) || (seq_state == ST_PULSE);
    r.state_code = seq_state;
    r.percent = charge_percent(held_mv);
    r.battery_mv = held_mv;
    r.request_current = ask;
    r.consumption_ma = budget_ma;
  endtask

  task automatic send_poll(input logic [BUS_W-1:0] bus, input logic [CUR_W-1:0] cur,
                           input logic [ADC_W-1:0] adc, input logic grant);
    int gap;
    poll_result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(20, 1);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, grant, adc, cur, bus};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_sequencer(bus, cur, adc, grant, r);
    result_q.push_back(r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (result_q.size() > 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_LOW_CURRENT:   thr_low_ma = val[MA_W-1:0];
      REG_LOW_LIMIT:     low_limit = val[LOW_W-1:0];
      REG_CHARGED_MV:    full_mv = val[BAT_W-1:0];
      REG_PRESENT_MV:    present_thr = val[BAT_W-1:0];
      REG_WAITING_MV:    wait_thr = val[BAT_W-1:0];
      REG_REQUEST_MA:    ask_ma = val[MA_W-1:0];
      REG_MEASURE_EVERY: measure_period = val;
      REG_STAB_POLLS:    settle_target = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] lo_ma, input logic [15:0] limit,
                                input logic [15:0] chg, input logic [15:0] pres,
                                input logic [15:0] wt, input logic [15:0] req,
                                input logic [15:0] meas, input logic [15:0] stab);
    drain_results();
    cfg_write(REG_LOW_CURRENT, lo_ma);
    cfg_write(REG_LOW_LIMIT, limit);
    cfg_write(REG_CHARGED_MV, chg);
    cfg_write(REG_PRESENT_MV, pres);
    cfg_write(REG_WAITING_MV, wt);
    cfg_write(REG_REQUEST_MA, req);
    cfg_write(REG_MEASURE_EVERY, meas);
    cfg_write(REG_STAB_POLLS, stab);
  endtask

  function automatic logic [BUS_W-1:0] pick_mv();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return 15'(MV_MARKS[$urandom_range(12)] + int'($urandom_range(2)) - 1);
    if (pick < 9) return 15'($urandom_range(5000));
    return 15'($urandom_range(32767));
  endfunction

  // sample reading above thr, sometimes the smallest one, with the edge just below now and then
  function automatic logic [ADC_W-1:0] adc_above(input logic [BAT_W-1:0] thr);
    int lo;
    int pick;
    lo = ((int'(thr) + 1) * 1024 + 4999) / 5000;
    pick = $urandom_range(7);
    if (lo > 1023) return 10'($urandom_range(1023));
    if (pick == 0) return 10'((lo > 0) ? lo - 1 : 0);
    if (pick == 1) return 10'(lo);
    return 10'($urandom_range(1023, lo));
  endfunction

  // poll shaped by the current state so that most runs get through to charging
  task automatic make_poll(input bit finish, output logic [BUS_W-1:0] bus,
                           output logic [CUR_W-1:0] cur, output logic [ADC_W-1:0] adc,
                           output logic grant);
    int pick;
    int cur_v;
    bus = 15'($urandom_range(32767));
    cur = 13'($urandom);
    adc = 10'($urandom_range(1023));
    grant = 1'($urandom_range(1));
    pick = $urandom_range(99);
    case (seq_state)
      ST_IDLE: begin
        if (finish || pick < 70) adc = adc_above(present_thr);
        if (finish) grant = 1'b1;
      end
      ST_WAIT: begin
        if (finish || pick < 75) adc = adc_above(wait_thr);
        if (finish) grant = 1'b1;
      end
      ST_START, ST_MEASURE: begin
        if (pick < 90) bus = pick_mv();
      end
      ST_CHARGE: begin
        if (finish || pick < low_pct) begin
          cur_v = int'(thr_low_ma) - 1 - int'($urandom_range(40));
          cur = 13'((cur_v < -4096) ? -4096 : cur_v);
        end else if (pick < 95) begin
          cur_v = int'(thr_low_ma) + int'($urandom_range(40));
          cur = 13'((cur_v > 4095) ? 4095 : cur_v);
        end
      end
      ST_ENDCHK: begin
        if (finish) begin
          bus = 15'($urandom_range(32767, int'(full_mv) + 1));
        end else begin
          bus = pick_mv();
          if (bus > full_mv) bus = ($urandom_range(3) == 0) ? 15'(full_mv)
                                                             : 15'($urandom_range(full_mv));
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic run_random_polls(input int n, input bit finish);
    logic [BUS_W-1:0] bus;
    logic [CUR_W-1:0] cur;
    logic [ADC_W-1:0] adc;
    logic grant;
    repeat (n) begin
      make_poll(finish, bus, cur, adc, grant);
      send_poll(bus, cur, adc, grant);
    end
  endtask

  task automatic test_state_walk();
    send_poll(15'd100, 13'd5, 10'd700, 1'b1);
    send_poll(15'd200, 13'd6, 10'd800, 1'b0);
    drain_results();
    cfg_write(REG_STAB_POLLS, 16'd0);
    cfg_write(REG_MEASURE_EVERY, 16'd2);
    cfg_write(REG_LOW_LIMIT, 16'd0);
    send_poll(15'd0, 13'd0, 10'd0, 1'b0);
    send_poll(15'd0, 13'd0, 10'd0, 1'b1);
    send_poll(15'd1234, 13'd20, 10'd512, 1'b1);      // exactly at present level
    send_poll(15'h7FFF, 13'h1000, 10'h3FF, 1'b0);
    send_poll(15'd50, 13'd0, 10'd410, 1'b0);         // just above waiting level
    send_poll(15'd50, 13'd0, 10'd409, 1'b1);         // just below: back to idle
    send_poll(15'd50, 13'd0, 10'h3FF, 1'b1);
    send_poll(15'd4200, 13'd0, 10'd0, 1'b0);
    send_poll(15'd0, 13'd12, 10'd0, 1'b0);           // current at threshold is not low
    send_poll(15'd0, 13'h0FFF, 10'd0, 1'b0);
    send_poll(15'd4199, 13'd0, 10'd0, 1'b0);
    send_poll(15'd0, 13'd11, 10'd0, 1'b0);
    send_poll(15'd4100, 13'd0, 10'd0, 1'b0);         // at charged level: reset pulse
    send_poll(15'd0, 13'd0, 10'd0, 1'b0);
    send_poll(15'd0, 13'd0, 10'd0, 1'b0);
  endtask

  task automatic test_small_counters();
    apply_settings(12, 3, 4100, 2500, 2000, 1000, 3, 2);
    low_pct = 30;
    run_random_polls(90, 1'b0);
  endtask

  task automatic test_max_settings();
    apply_settings(4095, 15, 8191, 0, 0, 4095, 65535, 1);
    low_pct = 92;
    run_random_polls(70, 1'b0);
  endtask

  task automatic test_min_settings();
    apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
    low_pct = 30;
    run_random_polls(50, 1'b0);
  endtask

  task automatic test_mixed_settings();
    apply_settings(16'($urandom_range(4095)), 16'($urandom_range(15)),
                   16'($urandom_range(5000, 3000)), 16'($urandom_range(5000)),
                   16'($urandom_range(5000)), 16'($urandom_range(4095)),
                   16'($urandom_range(8)), 16'($urandom_range(8)));
    low_pct = $urandom_range(60, 10);
    run_random_polls(80, 1'b0);
  endtask

  task automatic test_stabilize_ceiling();
    apply_settings(12, 3, 4100, 2500, 2000, 1000, 100, 65535);
    low_pct = 50;
    run_random_polls(20, 1'b0);
  endtask

  task automatic test_charged_end();
    int tries;
    apply_settings(100, 2, 4000, 100, 100, 500, 4, 1);
    tries = 0;
    while (seq_state != ST_DONE && tries < 60) begin
      run_random_polls(1, 1'b1);
      tries++;
    end
    run_random_polls(5, 1'b1);
  endtask

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(3);
      ready_left = $urandom_range(64, 8);
      ready_bits = $urandom;
    end
    ready_left--;
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(1));
      2: begin
        out_tready <= ready_bits[0];
        ready_bits = {ready_bits[0], ready_bits[31:1]};
      end
      default: out_tready <= ($urandom_range(7) == 0);
    endcase
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    poll_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: result word %h expected none", $time, out_tdata);
        error_count++;
      end else begin
        exp_r = result_q.pop_front();
        check_field("charge_enable", exp_r.charge_enable, out_tdata[0]);
        check_field("state_code", int'(exp_r.state_code), out_tdata[4:1]);
        check_field("percent", exp_r.percent, out_tdata[11:5]);
        check_field("battery_mv", exp_r.battery_mv, out_tdata[26:12]);
        check_field("request_current", exp_r.request_current, out_tdata[27]);
        check_field("consumption_ma", $signed(exp_r.consumption_ma),
                    $signed(out_tdata[40:28]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_image();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_state_walk();
    test_small_counters();
    test_max_settings();
    test_min_settings();
    test_mixed_settings();
    test_mixed_settings();
    test_stabilize_ceiling();
    test_charged_end();
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
